/* rtl/core/chb_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// chb_pkg: shared types and constants of the histogram binner
// Command and result words, command codes, register indexes, queue sizing
// and the back-end state type.
// ----------------------------------------------------------------------------
package chb_pkg;

  // Command codes; code 3 leaves the state alone and reports the totals.
  typedef enum logic [1:0] {
    CMD_ADD      = 2'd0,
    CMD_READ_BIN = 2'd1,
    CMD_READ_SUM = 2'd2
  } cmd_t;

  // Configuration register indexes
  localparam logic [1:0] CFG_BIN_ORIGIN  = 2'd0;
  localparam logic [1:0] CFG_BIN_SCALE   = 2'd1;
  localparam logic [1:0] CFG_BINS_IN_USE = 2'd2;

  localparam int HIT_W  = 10;
  localparam int BIU_W  = 11;

  // Queue between front and back end
  localparam int QDEPTH = 4;
  localparam int QPTR_W = 2;
  localparam int QCNT_W = 3;

  typedef struct packed {
    logic [1:0]         command;
    logic signed [31:0] sample;
    logic [HIT_W-1:0]   bin_index;
  } in_word_t;

  typedef struct packed {
    logic [31:0]        bin_count;
    logic [HIT_W-1:0]   bin_hit;
    logic signed [63:0] sample_sum;
    logic [31:0]        sample_total;
  } out_word_t;

  typedef struct packed {
    logic              empty;
    logic [QCNT_W-1:0] count;
  } q_stat_t;

  typedef enum logic [1:0] {
    BK_CLEAR,
    BK_IDLE,
    BK_UPDATE
  } bk_state_t;

endpackage
`default_nettype wire

/* rtl/core/chb_front.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// chb_front: command intake and bin classification
// Two stages: origin subtract, then scale multiply; clamp and push to queue.
// ----------------------------------------------------------------------------
module chb_front
  import chb_pkg::*;
#(
  parameter int NUM_BINS = 1024,
  parameter int IDX_W    = 10,
  parameter int ENT_W    = 2 + IDX_W + HIT_W + 1 + 32
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             accept,
  input  wire in_word_t         in_word,
  input  wire logic [31:0]      bin_origin,
  input  wire logic [31:0]      bin_scale,
  input  wire logic [BIU_W-1:0] bins_in_use,
  output logic                  push,
  output logic [ENT_W-1:0]      push_data,
  output logic [1:0]            inflight
);

  logic               s1_v_r;
  logic [1:0]         s1_cmd_r;
  logic [31:0]        s1_sample_r;
  logic [HIT_W-1:0]   s1_idx_r;
  logic signed [32:0] s1_diff_r;
  logic signed [32:0] diff_nxt;

  logic               s2_v_r;
  logic [1:0]         s2_cmd_r;
  logic [31:0]        s2_sample_r;
  logic [HIT_W-1:0]   s2_idx_r;
  logic               s2_nonpos_r;
  logic [31:0]        s2_prod_hi_r;
  logic [63:0]        prod;

  logic [31:0]        eff32;
  logic [31:0]        top32;
  logic [31:0]        bin32;
  logic [IDX_W-1:0]   ent_addr;
  logic [HIT_W-1:0]   ent_hit;
  logic               ent_ok;

  assign diff_nxt = {in_word.sample[31], in_word.sample} -
                    {bin_origin[31], bin_origin};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else begin
      s1_v_r <= accept;
    end
    if (accept) begin
      s1_cmd_r    <= in_word.command;
      s1_sample_r <= in_word.sample;
      s1_idx_r    <= in_word.bin_index;
      s1_diff_r   <= diff_nxt;
    end
  end

  // diff is positive and below 2^32 whenever the product is used
  assign prod = 64'(s1_diff_r[31:0]) * 64'(bin_scale);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_v_r <= 1'b0;
    end else begin
      s2_v_r <= s1_v_r;
    end
    if (s1_v_r) begin
      s2_cmd_r     <= s1_cmd_r;
      s2_sample_r  <= s1_sample_r;
      s2_idx_r     <= s1_idx_r;
      s2_nonpos_r  <= s1_diff_r[32] || (s1_diff_r == 33'sd0);
      s2_prod_hi_r <= prod[63:32];
    end
  end

  // Clamp bins in use to 1..NUM_BINS, then the bin to the top bin
  always_comb begin
    if (bins_in_use == '0) begin
      eff32 = 32'd1;
    end else if (32'(bins_in_use) > 32'(NUM_BINS)) begin
      eff32 = 32'(NUM_BINS);
    end else begin
      eff32 = 32'(bins_in_use);
    end
    top32 = eff32 - 32'd1;
    if (s2_nonpos_r) begin
      bin32 = '0;
    end else if (s2_prod_hi_r > top32) begin
      bin32 = top32;
    end else begin
      bin32 = s2_prod_hi_r;
    end
    if (s2_cmd_r == CMD_ADD) begin
      ent_addr = IDX_W'(bin32);
      ent_hit  = HIT_W'(bin32);
      ent_ok   = 1'b1;
    end else begin
      ent_addr = IDX_W'(s2_idx_r);
      ent_hit  = s2_idx_r;
      ent_ok   = (32'(s2_idx_r) < 32'(NUM_BINS));
    end
  end

  assign push      = s2_v_r;
  assign push_data = {s2_cmd_r, ent_addr, ent_hit, ent_ok, s2_sample_r};
  assign inflight  = 2'(s1_v_r) + 2'(s2_v_r);

endmodule
`default_nettype wire

/* rtl/core/chb_queue.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// chb_queue: small FIFO between front and back end
// Push is credit-guarded upstream; never pushed when full.
// ----------------------------------------------------------------------------
module chb_queue
  import chb_pkg::*;
#(
  parameter int WIDTH = 54
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             push,
  input  wire logic [WIDTH-1:0] push_data,
  input  wire logic             pop,
  output logic [WIDTH-1:0]      head,
  output q_stat_t               stat
);

  logic [WIDTH-1:0]  slot_r [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_r;
  logic [QPTR_W-1:0] rd_ptr_r;
  logic [QCNT_W-1:0] cnt_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      cnt_r <= cnt_r + QCNT_W'(push) - QCNT_W'(pop);
    end
    if (push) begin
      slot_r[wr_ptr_r] <= push_data;
    end
  end

  assign head       = slot_r[rd_ptr_r];
  assign stat.empty = (cnt_r == '0);
  assign stat.count = cnt_r;

endmodule
`default_nettype wire

/* rtl/core/chb_back.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// chb_back: bin store, running sum and sample count
// Clears the store after reset, then pops one command, reads its bin and,
// for an add, writes back the update on the next cycle.
// ----------------------------------------------------------------------------
module chb_back
  import chb_pkg::*;
#(
  parameter int NUM_BINS    = 1024,
  parameter int COUNT_WIDTH = 32,
  parameter int IDX_W       = 10,
  parameter int ENT_W       = 2 + IDX_W + HIT_W + 1 + 32
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic [ENT_W-1:0] head,
  input  wire q_stat_t          qstat,
  output logic                  pop,
  output logic                  clearing,
  output logic                  out_valid,
  output out_word_t             out_word
);

  localparam int OFS_OK   = 32;
  localparam int OFS_HIT  = 33;
  localparam int OFS_ADDR = OFS_HIT + HIT_W;

  logic [COUNT_WIDTH-1:0] mem [NUM_BINS];

  bk_state_t              state_r, state_nxt;
  logic [IDX_W-1:0]       clr_cnt_r;
  logic [ENT_W-1:0]       cur_r;
  logic [COUNT_WIDTH-1:0] rd_data_r;
  logic signed [63:0]     sum_r, sum_nxt;
  logic [31:0]            total_r, total_nxt;
  logic                   out_valid_r, out_valid_nxt;
  out_word_t              out_word_r, out_word_nxt;

  logic                   mem_we;
  logic [IDX_W-1:0]       mem_wa;
  logic [COUNT_WIDTH-1:0] mem_wd;

  logic [1:0]             cur_cmd;
  logic [IDX_W-1:0]       cur_addr;
  logic [HIT_W-1:0]       cur_hit;
  logic                   cur_ok;
  logic signed [31:0]     cur_sample;
  logic [IDX_W-1:0]       head_addr;

  logic [COUNT_WIDTH-1:0] cnt_inc;
  logic [COUNT_WIDTH-1:0] cnt_shown_src;
  logic [63:0]            cnt64;
  logic signed [63:0]     samp64;
  logic signed [63:0]     sum_add;

  assign cur_cmd    = cur_r[ENT_W-1 -: 2];
  assign cur_addr   = cur_r[OFS_ADDR +: IDX_W];
  assign cur_hit    = cur_r[OFS_HIT +: HIT_W];
  assign cur_ok     = cur_r[OFS_OK];
  assign cur_sample = cur_r[31:0];
  assign head_addr  = head[OFS_ADDR +: IDX_W];

  assign cnt_inc = (rd_data_r == '1) ? rd_data_r : rd_data_r + 1'b1;
  assign samp64  = 64'(cur_sample);
  assign sum_add = sum_r + samp64;

  always_comb begin
    state_nxt     = state_r;
    pop           = 1'b0;
    mem_we        = 1'b0;
    mem_wa        = cur_addr;
    mem_wd        = cnt_inc;
    sum_nxt       = sum_r;
    total_nxt     = total_r;
    out_valid_nxt = 1'b0;
    cnt_shown_src = '0;
    cnt64         = '0;
    out_word_nxt  = out_word_r;
    unique case (state_r)
      BK_CLEAR: begin
        mem_we = 1'b1;
        mem_wa = clr_cnt_r;
        mem_wd = '0;
        if (clr_cnt_r == IDX_W'(NUM_BINS - 1)) begin
          state_nxt = BK_IDLE;
        end
      end
      BK_IDLE: begin
        if (!qstat.empty) begin
          pop       = 1'b1;
          state_nxt = BK_UPDATE;
        end
      end
      BK_UPDATE: begin
        state_nxt     = BK_IDLE;
        out_valid_nxt = 1'b1;
        unique case (cur_cmd)
          CMD_ADD: begin
            mem_we        = 1'b1;
            cnt_shown_src = cnt_inc;
            // saturate the sum at the signed 64-bit limits
            if ((sum_r[63] == samp64[63]) && (sum_add[63] != sum_r[63])) begin
              sum_nxt = samp64[63] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
            end else begin
              sum_nxt = sum_add;
            end
            total_nxt = (total_r == '1) ? total_r : total_r + 1'b1;
          end
          CMD_READ_BIN: begin
            cnt_shown_src = cur_ok ? rd_data_r : '0;
          end
          default: begin
            cnt_shown_src = '0;
          end
        endcase
        cnt64 = 64'(cnt_shown_src);
        out_word_nxt.bin_count    = (cnt64 > 64'h0000_0000_FFFF_FFFF) ?
                                    32'hFFFF_FFFF : cnt64[31:0];
        out_word_nxt.bin_hit      = ((cur_cmd == CMD_ADD) || (cur_cmd == CMD_READ_BIN)) ?
                                    cur_hit : '0;
        out_word_nxt.sample_sum   = sum_nxt;
        out_word_nxt.sample_total = total_nxt;
      end
      default: begin
        state_nxt = BK_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= BK_CLEAR;
      clr_cnt_r   <= '0;
      sum_r       <= '0;
      total_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_cnt_r   <= clr_cnt_r + 1'b1;
      sum_r       <= sum_nxt;
      total_r     <= total_nxt;
      out_valid_r <= out_valid_nxt;
    end
    out_word_r <= out_word_nxt;
    if (pop) begin
      cur_r <= head;
    end
  end

  // Bin store: one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    if (pop) begin
      rd_data_r <= mem[head_addr];
    end
  end

  assign clearing  = (state_r == BK_CLEAR);
  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

endmodule
`default_nettype wire

/* rtl/core/clamped_histogram_binner_unit.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// clamped_histogram_binner_unit: fixed-width histogram engine
// Bins Q16.16 samples into a cleared store, keeps a saturating sum and count.
// ----------------------------------------------------------------------------
// Usage: after reset the unit sweeps its bin store to zero, one bin per
// cycle; busy stays high during that sweep. A command is taken on a
// rising edge with start high and busy low. Commands enter a two-stage
// front end (origin subtract, then a 32x32 multiply by the bin scale,
// then clamp) and wait in a four-word queue; the front end takes a word
// every cycle until the queue credits run out. The back end retires one
// word at a time: it pops a word with a registered read of the bin store,
// then writes back the update of an add, before it pops the next word. Each
// result appears on out_word for exactly one cycle with out_valid high; the
// receiver cannot stall it, so capture it on that edge. Results come back
// in command order.
// Write configuration only while the unit is idle.
module clamped_histogram_binner_unit
  import chb_pkg::*;
#(
  parameter int NUM_BINS    = 1024,
  parameter int COUNT_WIDTH = 32
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  output logic             busy,
  input  wire in_word_t    in_word,
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [31:0] cfg_wdata,
  output logic             out_valid,
  output out_word_t        out_word
);

  localparam int IDX_W = (NUM_BINS > 1) ? $clog2(NUM_BINS) : 1;
  localparam int ENT_W = 2 + IDX_W + HIT_W + 1 + 32;

  // Configuration registers
  logic [31:0]      bin_origin_r;
  logic [31:0]      bin_scale_r;
  logic [BIU_W-1:0] bins_in_use_r;

  logic             accept;
  logic             push;
  logic [ENT_W-1:0] push_data;
  logic [1:0]       inflight;
  logic             pop;
  logic [ENT_W-1:0] head;
  q_stat_t          qstat;
  logic             clearing;
  logic [QCNT_W-1:0] occupancy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bin_origin_r  <= '0;
      bin_scale_r   <= 32'h0001_0000;
      bins_in_use_r <= BIU_W'(1024);
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_BIN_ORIGIN:  bin_origin_r  <= cfg_wdata;
        CFG_BIN_SCALE:   bin_scale_r   <= cfg_wdata;
        CFG_BINS_IN_USE: bins_in_use_r <= cfg_wdata[BIU_W-1:0];
        default: begin
          // unmapped index: drop the write
        end
      endcase
    end
  end

  // Credit check: words in the queue plus words still in the front end
  assign occupancy = qstat.count + QCNT_W'(inflight);
  assign busy      = clearing || (occupancy >= QCNT_W'(QDEPTH));
  assign accept    = start && !busy;

  chb_front #(
    .NUM_BINS (NUM_BINS),
    .IDX_W    (IDX_W),
    .ENT_W    (ENT_W)
  ) u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .accept      (accept),
    .in_word     (in_word),
    .bin_origin  (bin_origin_r),
    .bin_scale   (bin_scale_r),
    .bins_in_use (bins_in_use_r),
    .push        (push),
    .push_data   (push_data),
    .inflight    (inflight)
  );

  chb_queue #(
    .WIDTH (ENT_W)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .head      (head),
    .stat      (qstat)
  );

  chb_back #(
    .NUM_BINS    (NUM_BINS),
    .COUNT_WIDTH (COUNT_WIDTH),
    .IDX_W       (IDX_W),
    .ENT_W       (ENT_W)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .head      (head),
    .qstat     (qstat),
    .pop       (pop),
    .clearing  (clearing),
    .out_valid (out_valid),
    .out_word  (out_word)
  );

endmodule
`default_nettype wire
